// ===== design/assert_macros.svh =====
// assertion macros used by the checker file qdc_checker.sv
// no dependencies; every macro samples on clk and is disabled while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent in this cycle implies consequent in the next cycle
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

// antecedent implies consequent in the same cycle
`define ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

`endif

// ===== design/qdc_pkg.sv =====
// shared constants, codes and transition table of the quadrature detent counter
// no dependencies
package qdc_pkg;

  localparam int COUNT_WIDTH_DEF = 16;
  localparam int ROT_W           = 16;
  localparam int PORT_W          = 8;
  localparam int POS_W           = 3;
  localparam int CFG_IDX_W       = 1;
  localparam int CFG_W           = 3;
  localparam int ACC_W           = 8;
  localparam int STEP_N_W        = 6;

  localparam logic [CFG_IDX_W-1:0] CFG_A_POS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_B_POS = 1'd1;

  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_CLEAR  = 1'b1;

  localparam logic [1:0] PHASE_DETENT = 2'b11;
  localparam logic [1:0] PHASE_RESET  = 2'b11;

  localparam logic [POS_W-1:0] A_POS_RESET = 3'd0;
  localparam logic [POS_W-1:0] B_POS_RESET = 3'd1;

  localparam logic signed [ACC_W:0] ACC_MAX = 9'sd127;
  localparam logic signed [ACC_W:0] ACC_MIN = -9'sd128;

  // indexed by {previous phase, new phase}
  localparam logic signed [1:0] STEP_TABLE [16] = '{
    2'sd0, 2'sd1, -2'sd1, 2'sd0, -2'sd1, 2'sd0, 2'sd0, 2'sd1,
    2'sd1, 2'sd0, 2'sd0, -2'sd1, 2'sd0, -2'sd1, 2'sd1, 2'sd0
  };

endpackage

// ===== design/quadrature_detent_counter.sv =====
// quadrature detent counter: phase decode, quarter-step accumulation, detent count
// depends on qdc_pkg
// an accepted word's result is registered in out_rot_r, or in skid_rot_r while a result waits
// throughput: one word per cycle while in_stall is low, set by the state update loop
// a two-deep result stage (output register plus skid) keeps input open while a result waits
// reset (synchronous, rst_n low): phase 11, accumulator and count zero, A at bit 0, B at bit 1
module quadrature_detent_counter #(
  parameter int COUNT_WIDTH = qdc_pkg::COUNT_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [qdc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [qdc_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_req_type,
  input  logic [qdc_pkg::PORT_W-1:0]    in_port_value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [qdc_pkg::ROT_W-1:0] out_rotation
);
  import qdc_pkg::*;

  localparam int EXT_W = (COUNT_WIDTH > ROT_W) ? COUNT_WIDTH : ROT_W;

  logic [POS_W-1:0]        a_pos_r, b_pos_r;
  logic [1:0]              phase_r, phase_nxt;
  logic signed [ACC_W-1:0] acc_r, acc_nxt;
  logic [COUNT_WIDTH-1:0]  count_r, count_nxt;
  logic                    out_valid_r, skid_valid_r;
  logic [ROT_W-1:0]        out_rot_r, skid_rot_r;

  logic                    accept, out_take;
  logic [1:0]              now_phase;
  logic signed [1:0]       step;
  logic signed [ACC_W:0]   acc_sum, acc_sat, mag;
  logic [STEP_N_W-1:0]     n_steps;
  logic signed [EXT_W-1:0] rot_ext;
  logic [ROT_W-1:0]        rot_nxt;

  assign accept    = in_valid & ~skid_valid_r;
  assign out_take  = out_valid_r & ~out_stall;
  assign in_stall  = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_rotation = out_rot_r;

  always_comb begin
    now_phase = {in_port_value[b_pos_r], in_port_value[a_pos_r]};
    step      = STEP_TABLE[{phase_r, now_phase}];
    acc_sum   = {acc_r[ACC_W-1], acc_r} + {{(ACC_W-1){step[1]}}, step};
    if (acc_sum > ACC_MAX) begin
      acc_sat = ACC_MAX;
    end else if (acc_sum < ACC_MIN) begin
      acc_sat = ACC_MIN;
    end else begin
      acc_sat = acc_sum;
    end
    // ceil of magnitude over four
    mag     = acc_sat[ACC_W] ? (9'sd3 - acc_sat) : (acc_sat + 9'sd3);
    n_steps = mag[STEP_N_W+1:2];

    phase_nxt = phase_r;
    acc_nxt   = acc_r;
    count_nxt = count_r;
    if (in_req_type == REQ_CLEAR) begin
      count_nxt = '0;
    end else begin
      phase_nxt = now_phase;
      if (now_phase == PHASE_DETENT) begin
        acc_nxt = '0;
        if (acc_sat[ACC_W]) begin
          count_nxt = count_r - COUNT_WIDTH'(n_steps);
        end else begin
          count_nxt = count_r + COUNT_WIDTH'(n_steps);
        end
      end else begin
        acc_nxt = acc_sat[ACC_W-1:0];
      end
    end
    rot_ext = EXT_W'(signed'(count_nxt));
    rot_nxt = rot_ext[ROT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_pos_r      <= A_POS_RESET;
      b_pos_r      <= B_POS_RESET;
      phase_r      <= PHASE_RESET;
      acc_r        <= '0;
      count_r      <= '0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_A_POS: a_pos_r <= cfg_wdata;
          CFG_B_POS: b_pos_r <= cfg_wdata;
          default:   ;
        endcase
      end
      if (accept) begin
        phase_r <= phase_nxt;
        acc_r   <= acc_nxt;
        count_r <= count_nxt;
      end
      if (skid_valid_r) begin
        if (out_take) begin
          skid_valid_r <= 1'b0;
        end
      end else if (accept) begin
        if (!out_valid_r || out_take) begin
          out_valid_r <= 1'b1;
        end else begin
          skid_valid_r <= 1'b1;
        end
      end else if (out_take) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_take) begin
        out_rot_r <= skid_rot_r;
      end
    end else if (accept) begin
      if (!out_valid_r || out_take) begin
        out_rot_r <= rot_nxt;
      end else begin
        skid_rot_r <= rot_nxt;
      end
    end
  end

endmodule

// ===== design/qdc_checker.sv =====
// port-level checker for the quadrature detent counter, bound to the top level
// depends on qdc_pkg and assert_macros.svh
`include "assert_macros.svh"

module qdc_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          in_req_type,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic signed [qdc_pkg::ROT_W-1:0] out_rotation
);
  import qdc_pkg::*;

  logic in_acc;
  logic clear_free;
  assign in_acc     = in_valid & ~in_stall;
  assign clear_free = in_acc && in_req_type == REQ_CLEAR && (!out_valid || !out_stall);

  // held result stays up
  `ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
  // input only backs up when a result is already waiting
  `ASSERT_SAME(a_stall_needs_out, in_stall, out_valid)
  // clear into a free output shows zero next cycle
  `ASSERT_NEXT(a_clear_zero, clear_free, out_valid && out_rotation == '0)
  // no result appears without a word
  `ASSERT_NEXT(a_no_phantom, !out_valid && !in_acc, !out_valid)

endmodule

bind quadrature_detent_counter qdc_checker u_qdc_checker (.*);
